// ----- rtl/epdm_pkg.sv -----
// ----------------------------------------------------------------------------
// epdm_pkg: shared definitions of the echo pulse distance meter
// Request codes, status codes, register map, queue sizing and the job record
// passed from the front part to the back part.
// ----------------------------------------------------------------------------
`default_nettype none

package epdm_pkg;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_CAPTURE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [1:0] REG_MIN_WIDTH = 2'd0;
    localparam logic [1:0] REG_MAX_WIDTH = 2'd1;
    localparam logic [1:0] REG_TIMEOUT   = 2'd2;

    localparam logic [15:0] MIN_WIDTH_RESET = 16'd36;
    localparam logic [15:0] MAX_WIDTH_RESET = 16'd725;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd25000;

    localparam int WIDTH_W = 16;
    localparam int DIST_W  = 14;

    // Division of 4*width by 29 is a multiply by ceil(2^23 / 29) and a shift.
    localparam int          DIV_SHIFT = 23;
    localparam int          DIV_RECIP_W = 19;
    localparam logic [18:0] DIV_RECIP = 19'd289263;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RISE = 3'b010,
        PH_FALL = 3'b100
    } t_phase;

    typedef struct packed {
        logic               timeout;
        logic [WIDTH_W-1:0] width;
    } t_job;

    typedef struct packed {
        logic [WIDTH_W-1:0] min_width;
        logic [WIDTH_W-1:0] max_width;
        logic [WIDTH_W-1:0] timeout;
    } t_cfg;

endpackage

`default_nettype wire

// ----- rtl/epdm_front.sv -----
// ----------------------------------------------------------------------------
// epdm_front: request intake and measurement sequencing
// Tracks the measurement phase, the rising stamp and the tick count, and
// queues a job for every request that ends a measurement.
// ----------------------------------------------------------------------------
`default_nettype none

module epdm_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_op,
    input  wire logic [epdm_pkg::WIDTH_W-1:0] i_capture_value,
    input  wire logic [epdm_pkg::WIDTH_W-1:0] i_timeout_ticks,
    input  wire logic                        i_full,
    output logic                             o_push,
    output epdm_pkg::t_job                   o_job
);
    import epdm_pkg::*;

    t_phase             r_phase, n_phase;
    logic [WIDTH_W-1:0] r_rise, n_rise;
    logic [WIDTH_W-1:0] r_wait, n_wait;
    logic [WIDTH_W-1:0] wait_inc;
    logic               accept;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;
    assign wait_inc = r_wait + 16'd1;

    always_comb begin
        n_phase = r_phase;
        n_rise  = r_rise;
        n_wait  = r_wait;
        o_push  = 1'b0;
        o_job.timeout = 1'b0;
        o_job.width   = i_capture_value - r_rise;
        if (accept) begin
            case (i_op)
                OP_START: begin
                    n_phase = PH_RISE;
                    n_rise  = '0;
                    n_wait  = '0;
                end
                OP_CAPTURE: begin
                    if (r_phase == PH_RISE) begin
                        n_rise  = i_capture_value;
                        n_phase = PH_FALL;
                    end else if (r_phase == PH_FALL) begin
                        n_phase = PH_IDLE;
                        o_push  = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        n_wait = wait_inc;
                        if (wait_inc >= i_timeout_ticks) begin
                            n_phase       = PH_IDLE;
                            o_push        = 1'b1;
                            o_job.timeout = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_rise  <= '0;
            r_wait  <= '0;
        end else begin
            r_phase <= n_phase;
            r_rise  <= n_rise;
            r_wait  <= n_wait;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/epdm_queue.sv -----
// ----------------------------------------------------------------------------
// epdm_queue: job queue between the front and back parts
// A small first-in first-out store that lets either side stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module epdm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire epdm_pkg::t_job i_job,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output epdm_pkg::t_job      o_job
);
    import epdm_pkg::*;

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = do_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = do_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (QUEUE_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (QUEUE_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/epdm_back.sv -----
// ----------------------------------------------------------------------------
// epdm_back: width check and distance conversion
// Takes a job from the queue, checks the width against the limits, scales it
// to a distance and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module epdm_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_job_valid,
    input  wire epdm_pkg::t_job               i_job,
    input  wire epdm_pkg::t_cfg               i_cfg,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [epdm_pkg::DIST_W-1:0]       o_distance,
    output logic [1:0]                        o_status
);
    import epdm_pkg::*;

    localparam int SCALED_W = WIDTH_W + 2;
    localparam int PROD_W   = SCALED_W + DIV_RECIP_W;

    logic                r_valid, n_valid;
    logic [DIST_W-1:0]   r_distance, n_distance;
    logic [1:0]          r_status, n_status;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   product;
    logic                in_range;

    assign scaled   = {i_job.width, 2'b00};
    assign product  = PROD_W'(scaled) * PROD_W'(DIV_RECIP);
    assign in_range = (i_job.width >= i_cfg.min_width) && (i_job.width <= i_cfg.max_width);
    assign o_pop    = i_job_valid && (!r_valid || i_ready);

    always_comb begin
        n_valid    = r_valid && !i_ready;
        n_distance = r_distance;
        n_status   = r_status;
        if (o_pop) begin
            n_valid = 1'b1;
            if (i_job.timeout) begin
                n_distance = '0;
                n_status   = ST_TIMEOUT;
            end else if (!in_range) begin
                n_distance = '0;
                n_status   = ST_RANGE;
            end else begin
                n_distance = product[DIV_SHIFT +: DIST_W];
                n_status   = ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_distance <= n_distance;
        r_status   <= n_status;
    end

    assign o_valid    = r_valid;
    assign o_distance = r_distance;
    assign o_status   = r_status;

endmodule

`default_nettype wire

// ----- rtl/echo_pulse_distance_meter_top.sv -----
// ----------------------------------------------------------------------------
// echo_pulse_distance_meter_top: ultrasonic echo pulse ranging
// Top level with the configuration registers, front part, queue and back part.
// ----------------------------------------------------------------------------
// Requests enter on i_valid/o_ready with i_op and i_capture_value: a start
// arms a measurement, the next two captures give the rising and falling
// timer stamps, and ticks count toward the timeout. A request that ends a
// measurement yields one result on o_valid/i_ready with o_distance and
// o_status; all other requests yield none.
// A request is taken every cycle while the queue is not full. Its result
// passes through the job queue into the output register; the multiply by
// the reciprocal of 29 sits between the queue head and that register.
// A four-entry job queue separates intake from the output register, so
// requests keep flowing while a result waits; o_ready drops only when the
// queue is full because the receiver holds i_ready low.
// Limits and timeout must be written over the APB port only while idle; the
// block does not enforce this. A synchronous reset returns it to idle,
// empties the queue, loads default limits (36, 725) and timeout (25000).
// ----------------------------------------------------------------------------
`default_nettype none

module echo_pulse_distance_meter_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [15:0] i_capture_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [13:0]      o_distance,
    output logic [1:0]       o_status,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import epdm_pkg::*;

    t_cfg       r_cfg, n_cfg;
    logic       cfg_write;
    logic [1:0] reg_index;
    logic       push, full, pop, head_valid;
    t_job       push_job, head_job;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (cfg_write) begin
            case (reg_index)
                REG_MIN_WIDTH: n_cfg.min_width = pwdata[WIDTH_W-1:0];
                REG_MAX_WIDTH: n_cfg.max_width = pwdata[WIDTH_W-1:0];
                REG_TIMEOUT:   n_cfg.timeout   = pwdata[WIDTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_MIN_WIDTH: prdata = {16'd0, r_cfg.min_width};
            REG_MAX_WIDTH: prdata = {16'd0, r_cfg.max_width};
            REG_TIMEOUT:   prdata = {16'd0, r_cfg.timeout};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_width <= MIN_WIDTH_RESET;
            r_cfg.max_width <= MAX_WIDTH_RESET;
            r_cfg.timeout   <= TIMEOUT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    epdm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_capture_value (i_capture_value),
        .i_timeout_ticks (r_cfg.timeout),
        .i_full          (full),
        .o_push          (push),
        .o_job           (push_job)
    );

    epdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job)
    );

    epdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (head_valid),
        .i_job       (head_job),
        .i_cfg       (r_cfg),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_distance  (o_distance),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

// ----- rtl/epdm_checker.sv -----
// ----------------------------------------------------------------------------
// epdm_checker: port-level checks of the echo pulse distance meter
// Watches the top-level ports and flags results that break the block's rules.
// ----------------------------------------------------------------------------
`default_nettype none

module epdm_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_valid,
    input  wire logic        i_ready,
    input  wire logic [13:0] o_distance,
    input  wire logic [1:0]  o_status
);
    import epdm_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance) && $stable(o_status))
        else $error("stalled result changed or dropped");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_distance == '0 &&
            (o_status == ST_RANGE || o_status == ST_TIMEOUT))
        else $error("failed measurement with nonzero distance or bad status");

    a_distance_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_OK |-> o_distance <= 14'd9039)
        else $error("distance beyond the largest possible width");

endmodule

bind echo_pulse_distance_meter_top epdm_checker u_epdm_checker (.*);

`default_nettype wire

// ----- bench/tb_echo_pulse_distance_meter_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_echo_pulse_distance_meter_top: self-checking bench for the echo meter
// Drives start, capture and tick requests with random gaps, stalls the result
// side at random, predicts every distance and status in the bench itself and
// compares each result in order. Limits and timeout are changed over APB
// between phases while the block is idle, covering the extreme settings.
// ----------------------------------------------------------------------------

module tb_echo_pulse_distance_meter_top;

    import epdm_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] capture;
    } t_echo_request;

    typedef struct packed {
        logic [13:0] distance;
        logic [1:0]  status;
    } t_echo_reading;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_op = OP_TICK;
    logic [15:0] i_capture_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [13:0] o_distance;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    echo_pulse_distance_meter_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_capture_value (i_capture_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_distance      (o_distance),
        .o_status        (o_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    t_echo_request pending_requests[$];
    t_echo_reading expected_readings[$];
    int            requests_in_flight = 0;
    int            error_count = 0;
    int            cycle_count = 0;
    bit            src_gaps_on = 1'b0;
    bit            sink_stalls_on = 1'b0;

    logic [15:0] lim_min = MIN_WIDTH_RESET;
    logic [15:0] lim_max = MAX_WIDTH_RESET;
    logic [15:0] lim_timeout = TIMEOUT_RESET;
    t_phase      meas_phase = PH_IDLE;
    logic [15:0] meas_rise = '0;
    logic [15:0] meas_ticks = '0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic predict_reading(input logic [1:0] op, input logic [15:0] capture);
        logic [15:0] width;
        t_echo_reading rd;
        case (op)
            OP_START: begin
                meas_phase = PH_RISE;
                meas_rise  = '0;
                meas_ticks = '0;
            end
            OP_CAPTURE: begin
                if (meas_phase == PH_RISE) begin
                    meas_rise  = capture;
                    meas_phase = PH_FALL;
                end else if (meas_phase == PH_FALL) begin
                    width = capture - meas_rise;
                    meas_phase = PH_IDLE;
                    if (width < lim_min || width > lim_max) begin
                        rd.distance = '0;
                        rd.status   = ST_RANGE;
                    end else begin
                        rd.distance = 14'((32'(width) * 4) / 29);
                        rd.status   = ST_OK;
                    end
                    expected_readings.push_back(rd);
                end
            end
            OP_TICK: begin
                if (meas_phase != PH_IDLE) begin
                    meas_ticks = meas_ticks + 16'd1;
                    if (meas_ticks >= lim_timeout) begin
                        meas_phase = PH_IDLE;
                        rd.distance = '0;
                        rd.status   = ST_TIMEOUT;
                        expected_readings.push_back(rd);
                    end
                end
            end
            default: begin
            end
        endcase
    endtask

    // Request driver.
    int src_gap_left = 0;
    always @(posedge i_clk) begin
        t_echo_request req;
        logic next_valid;
        next_valid = i_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_reading(i_op, i_capture_value);
                requests_in_flight--;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (src_gap_left > 0) begin
                    src_gap_left--;
                end else if (pending_requests.size() != 0) begin
                    req = pending_requests.pop_front();
                    i_op            <= req.op;
                    i_capture_value <= req.capture;
                    next_valid = 1'b1;
                    src_gap_left = src_gaps_on ? pick_gap() : 0;
                end
            end
        end
        i_valid <= next_valid;
    end

    // Result monitor and receiver stalls.
    int sink_stall_left = 0;
    always @(posedge i_clk) begin
        t_echo_reading exp_rd;
        logic next_ready;
        next_ready = 1'b0;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("unexpected result: distance %0d, status %0d", o_distance, o_status);
                    error_count++;
                end else begin
                    exp_rd = expected_readings.pop_front();
                    if (o_distance !== exp_rd.distance) begin
                        $error("distance: expected %0d, got %0d", exp_rd.distance, o_distance);
                        error_count++;
                    end
                    if (o_status !== exp_rd.status) begin
                        $error("status: expected %0d, got %0d", exp_rd.status, o_status);
                        error_count++;
                    end
                end
            end
            if (sink_stall_left > 0) begin
                sink_stall_left--;
            end else begin
                next_ready = 1'b1;
                if (sink_stalls_on && $urandom_range(0, 2) == 0) begin
                    sink_stall_left = pick_gap();
                end
            end
        end
        i_ready <= next_ready;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_echo_pulse_distance_meter_top NOT OK");
            $finish;
        end
    end

    task automatic push_request(input logic [1:0] op, input logic [15:0] capture);
        t_echo_request req;
        req.op      = op;
        req.capture = capture;
        requests_in_flight++;
        pending_requests.push_back(req);
    endtask

    task automatic wait_until_idle();
        while (requests_in_flight != 0 || expected_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (reg_idx)
            REG_MIN_WIDTH: lim_min = value;
            REG_MAX_WIDTH: lim_max = value;
            REG_TIMEOUT:   lim_timeout = value;
            default: begin
            end
        endcase
    endtask

    task automatic set_limits(input logic [15:0] min_w, input logic [15:0] max_w,
                              input logic [15:0] timeout);
        wait_until_idle();
        apb_write(REG_MIN_WIDTH, min_w);
        apb_write(REG_MAX_WIDTH, max_w);
        apb_write(REG_TIMEOUT, timeout);
    endtask

    function automatic logic [15:0] pick_width();
        case ($urandom_range(0, 7))
            0: return lim_min;
            1: return lim_max;
            2: return lim_min - 16'd1;
            3: return lim_max + 16'd1;
            4, 5: begin
                if (lim_min <= lim_max) return 16'($urandom_range(lim_min, lim_max));
                return 16'($urandom);
            end
            6: return 16'($urandom);
            default: return 16'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic int pick_tick_count();
        if (lim_timeout <= 40 && $urandom_range(0, 3) == 0) begin
            return $urandom_range(lim_timeout - 1, lim_timeout + 1);
        end
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0;
    endfunction

    task automatic queue_measurements(input int count);
        int sent;
        int ticks;
        int pre_ticks;
        logic [15:0] rise;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 12) begin
                push_request(2'($urandom_range(0, 3)), 16'($urandom));
                sent++;
            end else begin
                push_request(OP_START, 16'($urandom));
                ticks = pick_tick_count();
                pre_ticks = $urandom_range(0, ticks);
                repeat (pre_ticks) push_request(OP_TICK, 16'($urandom));
                rise = 16'($urandom);
                push_request(OP_CAPTURE, rise);
                repeat (ticks - pre_ticks) push_request(OP_TICK, 16'($urandom));
                sent += ticks + 2;
                if ($urandom_range(0, 9) != 0) begin
                    push_request(OP_CAPTURE, rise + pick_width());
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Requests while idle are ignored, as is the unused code.
        push_request(OP_CAPTURE, 16'hFFFF);
        push_request(OP_TICK, 16'h0000);
        push_request(2'd3, 16'h5A5A);
        // Shortest and longest accepted widths.
        push_request(OP_START, 16'h0000);
        push_request(OP_CAPTURE, 16'd100);
        push_request(OP_CAPTURE, 16'd136);
        push_request(OP_START, 16'h0000);
        push_request(OP_CAPTURE, 16'd1000);
        push_request(OP_CAPTURE, 16'd1725);
        // Just outside either limit.
        push_request(OP_START, 16'h0000);
        push_request(OP_CAPTURE, 16'd0);
        push_request(OP_CAPTURE, 16'd35);
        push_request(OP_START, 16'h0000);
        push_request(OP_CAPTURE, 16'd0);
        push_request(OP_CAPTURE, 16'd726);
        // Restart while armed, then a falling stamp that wraps past zero.
        push_request(OP_START, 16'h0000);
        push_request(OP_START, 16'hFFFF);
        push_request(OP_CAPTURE, 16'd65500);
        push_request(OP_CAPTURE, 16'd200);
        // Ticks and the unused code in the middle of a measurement.
        push_request(OP_START, 16'h0000);
        push_request(OP_CAPTURE, 16'd5);
        push_request(OP_TICK, 16'h0000);
        push_request(2'd3, 16'hA5A5);
        push_request(OP_CAPTURE, 16'hFFFF);

        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        queue_measurements(80);

        set_limits(16'd0, 16'd65535, 16'd65535);
        push_request(OP_START, 16'h0000);
        push_request(OP_CAPTURE, 16'd7);
        push_request(OP_CAPTURE, 16'd6);
        push_request(OP_START, 16'h0000);
        push_request(OP_CAPTURE, 16'd9);
        push_request(OP_CAPTURE, 16'd9);
        src_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        queue_measurements(90);

        // Minimum above maximum, and a timeout on the first tick.
        set_limits(16'd500, 16'd100, 16'd1);
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b1;
        queue_measurements(70);

        set_limits(16'd1000, 16'd5000, 16'd20);
        src_gaps_on = 1'b0;
        queue_measurements(90);

        set_limits(16'd65535, 16'd65535, 16'd8);
        src_gaps_on = 1'b1;
        sink_stalls_on = 1'b0;
        queue_measurements(70);

        set_limits(16'd0, 16'd0, 16'd300);
        sink_stalls_on = 1'b1;
        push_request(OP_START, 16'h0000);
        repeat (300) push_request(OP_TICK, 16'h0000);
        queue_measurements(60);

        wait_until_idle();
        if (error_count == 0) begin
            $display("tb_echo_pulse_distance_meter_top OK");
        end else begin
            $display("tb_echo_pulse_distance_meter_top NOT OK");
        end
        $finish;
    end

endmodule
